// ----- src/mfde_pkg.sv -----
// shared types, constants and bit helpers for the masked field deposit/extract block
`default_nettype none

package mfde_pkg;

  localparam int MAX_BYTES = 8;
  localparam int WORD_W    = 64;
  localparam int NUM_BYTES = WORD_W / 8;
  localparam int LEN_W     = 4;
  localparam int OFF_W     = 6;   // start of a byte's field bits, at most 56
  localparam int CNT_W     = 7;   // total field bits, up to 64
  localparam int BCNT_W    = 4;   // field bits in one byte, up to 8

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [63:0]        insn_bytes;
    logic [63:0]        field_mask;
    logic [63:0]        invert_mask;
    logic signed [63:0] operand_value;
    logic [3:0]         length_bytes;
    logic               is_signed;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        result_bytes;
    logic signed [63:0] decoded_value;
  } out_item_t;

  function automatic logic [BCNT_W-1:0] byte_popcount(input logic [7:0] m);
    logic [BCNT_W-1:0] c;
    c = '0;
    for (int j = 0; j < 8; j++) begin
      c = c + BCNT_W'(m[j]);
    end
    return c;
  endfunction

  // gather the bits of x under m toward bit 0
  function automatic logic [7:0] byte_pext(input logic [7:0] x, input logic [7:0] m);
    logic [7:0]        r;
    logic [BCNT_W-1:0] k;
    r = '0;
    k = '0;
    for (int j = 0; j < 8; j++) begin
      if (m[j]) begin
        r[k[2:0]] = x[j];
        k = k + 1'b1;
      end
    end
    return r;
  endfunction

  // scatter the low bits of v onto the set positions of m
  function automatic logic [7:0] byte_pdep(input logic [7:0] v, input logic [7:0] m);
    logic [7:0]        r;
    logic [BCNT_W-1:0] k;
    r = '0;
    k = '0;
    for (int j = 0; j < 8; j++) begin
      if (m[j]) begin
        r[j] = v[k[2:0]];
        k = k + 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/mfde_in_if.sv -----
// input channel: valid/ready with one request item
`default_nettype none

interface mfde_in_if
  import mfde_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/mfde_out_if.sv -----
// output channel: valid/ready with one result item
`default_nettype none

interface mfde_out_if
  import mfde_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/masked_field_deposit_extract.sv -----
// top level: four-stage pipelined bit deposit / extract over instruction bytes
//
// req_ch carries one request beat (operation, instruction bytes, field and
// invert masks, operand value, length, signedness); rsp_ch returns one
// result beat for each request, in order. Handshake on both channels is
// valid/ready, a beat moves when both are high.
// big_endian is written through cfg_wr_en/cfg_wr_data; the user must do so
// only while no request is in flight, which the block does not enforce. It
// sets whether the low value bits sit in the first or last instruction byte.
// rsp_ch.valid rises once the request has passed through the stage
// registers s1, s2, s3 and s4; one beat is accepted every cycle as long
// as rsp_ch.ready is high. The four stages are byte reorder, per-byte
// count and gather, per-byte placement, and final merge / sign extension.
// When the receiver holds rsp_ch.ready low, beats queue up in the stage
// registers (up to four) before req_ch.ready drops; nothing is lost or
// repeated. Reset empties the pipeline and clears big_endian to 0.
`default_nettype none

module masked_field_deposit_extract
  import mfde_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_wr_en,
  input  wire logic   cfg_wr_data,
  mfde_in_if.sink     req_ch,
  mfde_out_if.source  rsp_ch
);

  logic big_endian;

  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian <= 1'b0;
    end else if (cfg_wr_en) begin
      big_endian <= cfg_wr_data;
    end
  end

  // pipeline flow control
  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4 || rsp_ch.ready;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign req_ch.ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= req_ch.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  // stage 1: clamp length, limit the field mask to the length, reorder bytes
  logic [LEN_W-1:0]  len_c;
  logic [WORD_W-1:0] range_mask;
  logic [WORD_W-1:0] m_nat_c;
  logic [WORD_W-1:0] mp_c;
  logic [WORD_W-1:0] xp_c;

  always_comb begin
    if (req_ch.data.length_bytes > LEN_W'(MAX_BYTES)) begin
      len_c = LEN_W'(MAX_BYTES);
    end else begin
      len_c = req_ch.data.length_bytes;
    end
    for (int b = 0; b < NUM_BYTES; b++) begin
      range_mask[8*b +: 8] = (LEN_W'(b) < len_c) ? 8'hff : 8'h00;
    end
    m_nat_c = req_ch.data.field_mask & range_mask;
  end

  mfde_byte_perm u_perm_mask (
    .din  (m_nat_c),
    .len  (len_c),
    .rev  (big_endian),
    .dout (mp_c)
  );

  mfde_byte_perm u_perm_bits (
    .din  (req_ch.data.insn_bytes ^ req_ch.data.invert_mask),
    .len  (len_c),
    .rev  (big_endian),
    .dout (xp_c)
  );

  logic              s1_op, s1_sgn, s1_big;
  logic [LEN_W-1:0]  s1_len;
  logic [WORD_W-1:0] s1_insn, s1_inv, s1_value, s1_m_nat, s1_mp, s1_xp;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_op    <= req_ch.data.operation;
      s1_sgn   <= req_ch.data.is_signed;
      s1_big   <= big_endian;
      s1_len   <= len_c;
      s1_insn  <= req_ch.data.insn_bytes;
      s1_inv   <= req_ch.data.invert_mask;
      s1_value <= req_ch.data.operand_value;
      s1_m_nat <= m_nat_c;
      s1_mp    <= mp_c;
      s1_xp    <= xp_c;
    end
  end

  // stage 2: per-byte field counts, running offsets, per-byte gather
  logic [OFF_W-1:0]  off_c [NUM_BYTES];
  logic [CNT_W-1:0]  total_c;
  logic [WORD_W-1:0] cp_c;

  always_comb begin
    logic [CNT_W-1:0] run;
    run = '0;
    for (int b = 0; b < NUM_BYTES; b++) begin
      off_c[b]         = run[OFF_W-1:0];
      run              = run + CNT_W'(byte_popcount(s1_mp[8*b +: 8]));
      cp_c[8*b +: 8]   = byte_pext(s1_xp[8*b +: 8], s1_mp[8*b +: 8]);
    end
    total_c = run;
  end

  logic              s2_op, s2_sgn, s2_big;
  logic [LEN_W-1:0]  s2_len;
  logic [CNT_W-1:0]  s2_total;
  logic [OFF_W-1:0]  s2_off [NUM_BYTES];
  logic [WORD_W-1:0] s2_insn, s2_inv, s2_value, s2_m_nat, s2_mp, s2_cp;

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_op    <= s1_op;
      s2_sgn   <= s1_sgn;
      s2_big   <= s1_big;
      s2_len   <= s1_len;
      s2_total <= total_c;
      s2_off   <= off_c;
      s2_insn  <= s1_insn;
      s2_inv   <= s1_inv;
      s2_value <= s1_value;
      s2_m_nat <= s1_m_nat;
      s2_mp    <= s1_mp;
      s2_cp    <= cp_c;
    end
  end

  // stage 3: place gathered bytes at their offsets, scatter value slices
  logic [WORD_W-1:0] acc_c;
  logic [WORD_W-1:0] dp_c;

  always_comb begin
    logic [WORD_W-1:0] slice;
    acc_c = '0;
    for (int b = 0; b < NUM_BYTES; b++) begin
      acc_c          = acc_c | (WORD_W'(s2_cp[8*b +: 8]) << s2_off[b]);
      slice          = s2_value >> s2_off[b];
      dp_c[8*b +: 8] = byte_pdep(slice[7:0], s2_mp[8*b +: 8]);
    end
  end

  logic              s3_op, s3_sgn, s3_big;
  logic [LEN_W-1:0]  s3_len;
  logic [CNT_W-1:0]  s3_total;
  logic [WORD_W-1:0] s3_insn, s3_inv, s3_m_nat, s3_acc, s3_dp;

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_op    <= s2_op;
      s3_sgn   <= s2_sgn;
      s3_big   <= s2_big;
      s3_len   <= s2_len;
      s3_total <= s2_total;
      s3_insn  <= s2_insn;
      s3_inv   <= s2_inv;
      s3_m_nat <= s2_m_nat;
      s3_acc   <= acc_c;
      s3_dp    <= dp_c;
    end
  end

  // stage 4: restore byte order and merge, or return the gathered value, sign-extended if is_signed
  logic [WORD_W-1:0] dn_c;
  logic [WORD_W-1:0] res_c;
  logic [WORD_W-1:0] dec_c;
  logic [CNT_W-1:0]  top_idx;

  mfde_byte_perm u_perm_back (
    .din  (s3_dp),
    .len  (s3_len),
    .rev  (s3_big),
    .dout (dn_c)
  );

  assign top_idx = s3_total - CNT_W'(1);

  always_comb begin
    if (s3_op == OP_ENCODE) begin
      res_c = s3_insn | (dn_c ^ (s3_inv & s3_m_nat));
      dec_c = '0;
    end else begin
      res_c = s3_insn;
      dec_c = s3_acc;
      if (s3_sgn && (s3_total != '0) && (s3_total < CNT_W'(WORD_W))
          && s3_acc[top_idx[OFF_W-1:0]]) begin
        dec_c = s3_acc | ({WORD_W{1'b1}} << s3_total);
      end
    end
  end

  out_item_t s4_item;

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_item.result_bytes  <= res_c;
      s4_item.decoded_value <= dec_c;
    end
  end

  assign rsp_ch.valid = v4;
  assign rsp_ch.data  = s4_item;

endmodule

`default_nettype wire

// ----- src/mfde_byte_perm.sv -----
// byte reorder within the instruction length: reverses bytes 0..len-1 when rev is set
`default_nettype none

module mfde_byte_perm
  import mfde_pkg::*;
(
  input  wire logic [WORD_W-1:0] din,
  input  wire logic [LEN_W-1:0]  len,
  input  wire logic              rev,
  output logic      [WORD_W-1:0] dout
);

  for (genvar n = 0; n < NUM_BYTES; n++) begin : g_byte
    logic [LEN_W-1:0] src;
    logic             in_len;

    assign src    = len - LEN_W'(1) - LEN_W'(n);
    assign in_len = LEN_W'(n) < len;

    always_comb begin
      if (rev && in_len) begin
        dout[8*n +: 8] = din[8*src[2:0] +: 8];
      end else begin
        dout[8*n +: 8] = din[8*n +: 8];
      end
    end
  end

endmodule

`default_nettype wire
